[sv/vsa_pkg.sv]
// shared types, codes and constants of the voice slot allocator
package vsa_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic signed [31:0] BEST_INIT = 32'sh7fffffff;
	localparam logic [8:0] CHAN_ANY = 9'h1ff;
	localparam logic [3:0] FREED_MAX = 4'hf;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STOP  = 1'b1
	} op_t;

	typedef enum logic {
		REG_LISTENER = 1'b0,
		REG_STREAM   = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_EMPTY    = 3'd0,
		ST_REPLACED = 3'd1,
		ST_KEPT     = 3'd2,
		ST_NONE     = 3'd3,
		ST_STOP     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [15:0]        entity;
		logic signed [8:0]  ent_channel;
		logic [15:0]        sound_id;
		logic               sound_loops;
		logic [23:0]        sound_length;
		logic [31:0]        now_time;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [2:0] slot_index;
		logic [3:0] freed_count;
	} res_t;

	typedef struct packed {
		logic [15:0] listener_entity;
		logic [7:0]  stream_channel;
	} cfg_t;

	typedef struct packed {
		logic        busy;
		logic [15:0] entity;
		logic [7:0]  chan;
		logic [15:0] sound;
		logic        looping;
		logic [31:0] end_time;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

endpackage

[sv/voice_slot_allocator.sv]
// voice slot allocator: start requests steal a slot, stop requests free slots
// Requests enter on s_axis (tuser holds the operation: start or stop), one
// result per request leaves on m_axis. Configuration registers (listener
// entity, stream channel) are written through cfg_we/cfg_addr/cfg_wdata
// while no request is in flight; the user must keep to this, as the block
// itself does not enforce it. A write takes effect at that clock edge.
// The slot table lives in one ram with a registered read; the sequencer
// reads one slot a cycle, so a request scans every slot, a start then
// passes a decide state, and every request ends in a done state that
// hands the result to the output register. A start ends its scan early
// on a same entity and channel match. The next request is accepted once
// the result has been handed over.
// One request is worked at a time.
// The output register holds a finished result while the next request is
// accepted and scanned; a stalled receiver only holds the sequencer once
// its next result is ready. Reset clears per-slot valid flags, so every slot
// reads as free and zero at once, with no clearing pass; the registers return
// to listener entity 0 and stream channel 5.
module voice_slot_allocator
	import vsa_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// entity, ent_channel, sound_id, sound_loops, sound_length, now_time
	input  logic [103:0]          s_axis_tdata,
	// operation
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status, slot_index, freed_count
	output logic [15:0]           m_axis_tdata
);

	cfg_t cfg_q;
	req_t req;
	res_t res, out_q;
	logic res_valid, res_ready, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.listener_entity <= 16'd0;
			cfg_q.stream_channel  <= 8'd5;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_LISTENER: cfg_q.listener_entity <= cfg_wdata[15:0];
				REG_STREAM:   cfg_q.stream_channel  <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		req.op           = op_t'(s_axis_tuser[0]);
		req.entity       = s_axis_tdata[15:0];
		req.ent_channel  = $signed(s_axis_tdata[24:16]);
		req.sound_id     = s_axis_tdata[40:25];
		req.sound_loops  = s_axis_tdata[41];
		req.sound_length = s_axis_tdata[65:42];
		req.now_time     = s_axis_tdata[97:66];
	end

	vsa_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_valid(s_axis_tvalid),
		.req_ready(s_axis_tready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.freed_count, out_q.slot_index, out_q.status};

	// a freshly accepted request cannot finish in the next cycle
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !res_valid)
		else $error("result offered right after request accept");

	// only stop transactions report freed slots
	a_freed_only_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_STOP |-> res.freed_count == 4'd0)
		else $error("freed count on a start result");

	// stop and no-slot results carry slot index zero
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_STOP || res.status == ST_NONE)
		|-> res.slot_index == 3'd0)
		else $error("slot index set on stop or no-slot result");

	// the sequencer never accepts while a result is offered
	a_accept_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && s_axis_tready))
		else $error("accepting a request while a result is pending");

endmodule

[sv/vsa_ram.sv]
// generic single-write, single-read ram with registered read data
module vsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/vsa_ctrl.sv]
// slot table sequencer: scans the slot ram, picks or frees slots, writes back
module vsa_ctrl
	import vsa_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = $clog2(SLOTS);
	localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

	state_t state_q, state_d;
	logic [SLOTS-1:0] valid_q;

	req_t              req_q;
	logic [AW-1:0]     proc_q;
	logic signed [31:0] best_q;
	logic [AW-1:0]     pick_q;
	slot_rec_t         pick_rec_q;
	logic              found_q;
	logic [3:0]        freed_q;
	res_t              res_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	slot_rec_t         wrec, rec;
	logic [REC_W-1:0]  ram_rdata;

	logic [7:0]         ch8;
	logic               any_chan, nonzero, req_is_lsn, last;
	logic signed [31:0] life;
	logic               skip_stream, imm_hit, skip_lsn, better, take_imm, take_cand;
	logic               stop_hit, same_loop;
	logic [3:0]         freed_nxt;
	slot_rec_t          freed_rec, new_rec;

	vsa_ram #(
		.WIDTH(REC_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wrec),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// entries never written read as the reset record
	assign rec = valid_q[proc_q] ? slot_rec_t'(ram_rdata) : '0;

	assign ch8        = req_q.ent_channel[7:0];
	assign any_chan   = req_q.ent_channel == CHAN_ANY;
	assign nonzero    = |req_q.ent_channel;
	assign req_is_lsn = req_q.entity == cfg.listener_entity;
	assign last       = proc_q == LAST_IDX;
	assign life       = $signed(rec.end_time - req_q.now_time);

	assign skip_stream = rec.busy && rec.chan == cfg.stream_channel;
	assign imm_hit     = nonzero && rec.entity == req_q.entity && (rec.chan == ch8 || any_chan);
	assign skip_lsn    = rec.busy && rec.entity == cfg.listener_entity && !req_is_lsn;
	assign better      = life < best_q;
	assign take_imm    = !skip_stream && imm_hit;
	assign take_cand   = !skip_stream && !imm_hit && !skip_lsn && better;

	assign stop_hit  = rec.busy && rec.entity == req_q.entity && rec.chan == ch8;
	assign freed_nxt = (stop_hit && freed_q != FREED_MAX) ? freed_q + 4'd1 : freed_q;

	assign same_loop = pick_rec_q.busy && pick_rec_q.looping
		&& pick_rec_q.entity == req_q.entity && pick_rec_q.chan == ch8
		&& pick_rec_q.sound == req_q.sound_id;

	always_comb begin
		freed_rec = rec;
		freed_rec.busy = 1'b0;
		freed_rec.looping = 1'b0;
		new_rec.busy = 1'b1;
		new_rec.entity = req_q.entity;
		new_rec.chan = ch8;
		new_rec.sound = req_q.sound_id;
		new_rec.looping = req_q.sound_loops;
		new_rec.end_time = req_q.now_time + 32'(req_q.sound_length);
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		raddr     = proc_q + AW'(1);
		we        = 1'b0;
		waddr     = proc_q;
		wrec      = freed_rec;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				raddr = '0;
				if (req_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (req_q.op == OP_STOP) begin
					we = stop_hit;
					if (last) begin
						state_d = S_DONE;
					end
				end else if (take_imm || last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				we = found_q && !same_loop;
				waddr = pick_q;
				wrec = new_rec;
				state_d = S_DONE;
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q   <= req;
				proc_q  <= '0;
				best_q  <= BEST_INIT;
				found_q <= 1'b0;
				freed_q <= '0;
			end
			S_SCAN: begin
				proc_q <= proc_q + AW'(1);
				if (req_q.op == OP_STOP) begin
					freed_q <= freed_nxt;
					res_q <= '{status: ST_STOP, slot_index: 3'd0, freed_count: freed_nxt};
				end else if (take_imm || take_cand) begin
					pick_q     <= proc_q;
					pick_rec_q <= rec;
					found_q    <= 1'b1;
					if (take_cand) begin
						best_q <= life;
					end
				end
			end
			S_DECIDE: begin
				priority if (!found_q) begin
					res_q <= '{status: ST_NONE, slot_index: 3'd0, freed_count: 4'd0};
				end else if (same_loop) begin
					res_q <= '{status: ST_KEPT, slot_index: 3'(pick_q), freed_count: 4'd0};
				end else begin
					res_q <= '{status: pick_rec_q.busy ? ST_REPLACED : ST_EMPTY,
						slot_index: 3'(pick_q), freed_count: 4'd0};
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule
